@@ rtl/chd_pkg.sv @@
`timescale 1ns / 1ps

package chd_pkg;

  localparam int unsigned SIZE_HEX_DIGITS_DEF = 8;

  localparam int unsigned PHASE_W = 3;

  localparam logic [PHASE_W-1:0] PH_SIZE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_EXT     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SIZE_LF = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DATA    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DATA_CR = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DATA_LF = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd6;
  localparam logic [PHASE_W-1:0] PH_ERROR   = 3'd7;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [2:0] TERM_LEN = 3'd5;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       body_done;
    logic       format_error;
  } chd_result_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      res = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      res = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      res = {1'b1, 4'(c - 8'h37)};
    end
    return res;
  endfunction

  function automatic logic [7:0] term_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_ZERO;
      3'd1:    ch = CH_CR;
      3'd2:    ch = CH_LF;
      3'd3:    ch = CH_CR;
      3'd4:    ch = CH_LF;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/chd_parser.sv @@
`timescale 1ns / 1ps

module chd_parser import chd_pkg::*; #(
  parameter int unsigned SIZE_HEX_DIGITS = SIZE_HEX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [7:0]  data_byte,
  input  logic        start,
  output chd_result_t result
);

  localparam int unsigned CNT_W = $clog2(SIZE_HEX_DIGITS + 1);

  logic [PHASE_W-1:0] phase_r, phase_nxt, phase_cur;
  logic [31:0]        acc_r, acc_nxt, acc_cur;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt, cnt_cur;
  logic [31:0]        rem_r, rem_nxt, rem_cur;
  logic               err_r, err_nxt, err_cur;
  logic               done_r, done_nxt, done_cur;
  logic [2:0]         term_r, term_nxt, term_cur;
  logic [4:0]         hex;
  logic [2:0]         term_step;
  logic               pay_vld;

  always_comb begin
    phase_cur = start ? PH_SIZE : phase_r;
    acc_cur   = start ? 32'd0 : acc_r;
    cnt_cur   = start ? '0 : cnt_r;
    rem_cur   = start ? 32'd0 : rem_r;
    err_cur   = start ? 1'b0 : err_r;
    done_cur  = start ? 1'b0 : done_r;
    term_cur  = start ? 3'd0 : term_r;

    hex = hex_decode(data_byte);
    if (term_cur < TERM_LEN && data_byte == term_char(term_cur)) begin
      term_step = term_cur + 3'd1;
    end else begin
      term_step = (data_byte == CH_ZERO) ? 3'd1 : 3'd0;
    end

    phase_nxt = phase_cur;
    acc_nxt   = acc_cur;
    cnt_nxt   = cnt_cur;
    rem_nxt   = rem_cur;
    err_nxt   = err_cur;
    done_nxt  = done_cur;
    term_nxt  = term_cur;
    pay_vld   = 1'b0;

    unique case (phase_cur)
      PH_SIZE: begin
        if (hex[4]) begin
          if (cnt_cur >= CNT_W'(SIZE_HEX_DIGITS)) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_ERROR;
            term_nxt  = (data_byte == CH_ZERO) ? 3'd1 : 3'd0;
          end else begin
            acc_nxt = {acc_cur[27:0], hex[3:0]};
            cnt_nxt = cnt_cur + CNT_W'(1);
          end
        end else if (data_byte == CH_CR) begin
          phase_nxt = PH_SIZE_LF;
        end else begin
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        if (data_byte == CH_CR) begin
          phase_nxt = PH_SIZE_LF;
        end
      end
      PH_SIZE_LF: begin
        if (data_byte != CH_LF) begin
          err_nxt   = 1'b1;
          phase_nxt = PH_ERROR;
          term_nxt  = (data_byte == CH_ZERO) ? 3'd1 : 3'd0;
        end else if (acc_cur == 32'd0) begin
          done_nxt  = 1'b1;
          phase_nxt = PH_DONE;
        end else begin
          rem_nxt   = acc_cur;
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        pay_vld = 1'b1;
        if (rem_cur != 32'd0) begin
          rem_nxt = rem_cur - 32'd1;
        end
        if (rem_nxt == 32'd0) begin
          phase_nxt = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        if (data_byte == CH_CR) begin
          phase_nxt = PH_DATA_LF;
        end else begin
          err_nxt   = 1'b1;
          phase_nxt = PH_ERROR;
          term_nxt  = (data_byte == CH_ZERO) ? 3'd1 : 3'd0;
        end
      end
      PH_DATA_LF: begin
        if (data_byte == CH_LF) begin
          phase_nxt = PH_SIZE;
          acc_nxt   = 32'd0;
          cnt_nxt   = '0;
        end else begin
          err_nxt   = 1'b1;
          phase_nxt = PH_ERROR;
          term_nxt  = (data_byte == CH_ZERO) ? 3'd1 : 3'd0;
        end
      end
      PH_ERROR: begin
        term_nxt = term_step;
        if (term_step >= TERM_LEN) begin
          term_nxt  = TERM_LEN;
          done_nxt  = 1'b1;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    result.payload_byte  = pay_vld ? data_byte : 8'd0;
    result.payload_valid = pay_vld;
    result.body_done     = done_nxt;
    result.format_error  = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      acc_r   <= 32'd0;
      cnt_r   <= '0;
      rem_r   <= 32'd0;
      err_r   <= 1'b0;
      done_r  <= 1'b0;
      term_r  <= 3'd0;
    end else if (en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      err_r   <= err_nxt;
      done_r  <= done_nxt;
      term_r  <= term_nxt;
    end
  end

endmodule

@@ rtl/http_chunked_body_decoder_core.sv @@
`timescale 1ns / 1ps

// Chunked transfer body decoder. Body bytes enter on the in_ channel, one
// request per byte, with in_body_start high on the first byte of a body.
// Every request yields exactly one result request on the out_ channel,
// carrying the payload byte and its valid flag, the done flag and the sticky
// format error flag.
// A request is held in an input register and handled once the output
// register can take a result, when the parser updates its state and the
// result is written to the output register. The result then shows on the
// out_ ports. A new byte can be accepted in every cycle while the receiver
// does not stall, so throughput is one byte per clock. The rate is set by
// the parser state update.
// When the receiver stalls, the result register holds its contents, the
// input register holds its byte and in_stall rises only once both are full.
// Synchronous reset empties both registers and returns the parser to reading
// the size of the first chunk with all flags clear.

module http_chunked_body_decoder_core import chd_pkg::*; #(
  parameter int unsigned SIZE_HEX_DIGITS = SIZE_HEX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_body_byte,
  input  logic       in_body_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_payload_valid,
  output logic       out_body_done,
  output logic       out_format_error
);

  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_start_r;
  logic        out_vld_r;
  chd_result_t out_res_r;
  chd_result_t result;
  logic        adv;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  chd_parser #(
    .SIZE_HEX_DIGITS(SIZE_HEX_DIGITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .data_byte(in_byte_r),
    .start    (in_start_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (!out_vld_r || !out_stall) begin
        out_vld_r <= adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r  <= in_body_byte;
      in_start_r <= in_body_start;
    end
    if (adv) begin
      out_res_r <= result;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_payload_valid = out_res_r.payload_valid;
  assign out_body_done     = out_res_r.body_done;
  assign out_format_error  = out_res_r.format_error;

endmodule

@@ rtl/chd_checker.sv @@
`timescale 1ns / 1ps

module chd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_body_byte,
  input logic       in_body_start,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_payload_byte,
  input logic       out_payload_valid,
  input logic       out_body_done,
  input logic       out_format_error
);

  // Payload is only ever passed while the body is neither finished nor in error.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> !out_body_done && !out_format_error)
    else $error("payload byte passed while done or in error");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'd0)
    else $error("payload byte not zero on a non-payload result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_payload_valid) && $stable(out_body_done)
      && $stable(out_format_error))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_body_byte)
      && $stable(in_body_start))
    else $error("stalled request changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind http_chunked_body_decoder_core chd_checker u_chd_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import chd_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 470;
  localparam logic [7:0] TERM_SEQ [0:4] = '{CH_ZERO, CH_CR, CH_LF, CH_CR, CH_LF};

  typedef struct packed {
    logic [7:0] body_byte;
    logic       body_start;
  } body_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_body_byte = 8'h00;
  logic       in_body_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_payload_byte;
  logic       out_payload_valid;
  logic       out_body_done;
  logic       out_format_error;

  body_req_t   body_bytes_q[$];
  chd_result_t decoded_q[$];
  logic [7:0]  body_q[$];
  body_req_t   next_req;
  chd_result_t want;
  int          sent_cnt = 0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  logic [PHASE_W-1:0] dec_phase = PH_SIZE;
  logic [31:0]        dec_size = '0;
  int                 dec_ndigits = 0;
  logic [31:0]        dec_left = '0;
  logic               dec_err = 1'b0;
  logic               dec_done = 1'b0;
  int                 dec_match = 0;

  http_chunked_body_decoder_core uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_body_byte      (in_body_byte),
    .in_body_start     (in_body_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_payload_byte  (out_payload_byte),
    .out_payload_valid (out_payload_valid),
    .out_body_done     (out_body_done),
    .out_format_error  (out_format_error)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void put_byte(input logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endfunction

  function automatic void put_req(input body_req_t req);
    body_bytes_q.insert(body_bytes_q.size(), req);
  endfunction

  function automatic void put_result(input chd_result_t res);
    decoded_q.insert(decoded_q.size(), res);
  endfunction

  function automatic void enter_fault(input logic [7:0] c);
    dec_err = 1'b1;
    dec_phase = PH_ERROR;
    dec_match = (c == CH_ZERO) ? 1 : 0;
  endfunction

  function automatic chd_result_t decode_byte(input logic [7:0] c, input logic start);
    chd_result_t r;
    int digit;
    r = '0;
    digit = -1;
    if (c >= "0" && c <= "9") begin
      digit = c - "0";
    end else if (c >= "a" && c <= "f") begin
      digit = c - "a" + 10;
    end else if (c >= "A" && c <= "F") begin
      digit = c - "A" + 10;
    end
    if (start) begin
      dec_phase = PH_SIZE;
      dec_size = '0;
      dec_ndigits = 0;
      dec_left = '0;
      dec_err = 1'b0;
      dec_done = 1'b0;
      dec_match = 0;
    end
    case (dec_phase)
      PH_SIZE: begin
        if (digit >= 0) begin
          if (dec_ndigits >= SIZE_HEX_DIGITS_DEF) begin
            enter_fault(c);
          end else begin
            dec_size = {dec_size[27:0], 4'(digit)};
            dec_ndigits++;
          end
        end else if (c == CH_CR) begin
          dec_phase = PH_SIZE_LF;
        end else begin
          dec_phase = PH_EXT;
        end
      end
      PH_EXT: begin
        if (c == CH_CR) dec_phase = PH_SIZE_LF;
      end
      PH_SIZE_LF: begin
        if (c != CH_LF) begin
          enter_fault(c);
        end else if (dec_size == 0) begin
          dec_done = 1'b1;
          dec_phase = PH_DONE;
        end else begin
          dec_left = dec_size;
          dec_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        r.payload_valid = 1'b1;
        r.payload_byte = c;
        if (dec_left != 0) dec_left--;
        if (dec_left == 0) dec_phase = PH_DATA_CR;
      end
      PH_DATA_CR: begin
        if (c == CH_CR) dec_phase = PH_DATA_LF;
        else enter_fault(c);
      end
      PH_DATA_LF: begin
        if (c == CH_LF) begin
          dec_phase = PH_SIZE;
          dec_size = '0;
          dec_ndigits = 0;
        end else begin
          enter_fault(c);
        end
      end
      PH_ERROR: begin
        if (dec_match < 5 && c == TERM_SEQ[dec_match]) dec_match++;
        else dec_match = (c == CH_ZERO) ? 1 : 0;
        if (dec_match >= 5) begin
          dec_match = 5;
          dec_done = 1'b1;
          dec_phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    r.body_done = dec_done;
    r.format_error = dec_err;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        put_result(decode_byte(in_body_byte, in_body_start));
      end
      if (!in_valid || !in_stall) begin
        if (body_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = body_bytes_q.pop_front();
          in_valid <= 1'b1;
          in_body_byte <= next_req.body_byte;
          in_body_start <= next_req.body_start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result request: payload_byte %0h", out_payload_byte);
        fail_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (out_payload_byte !== want.payload_byte) begin
          $error("payload_byte expected %0h actual %0h", want.payload_byte, out_payload_byte);
          fail_cnt++;
        end
        if (out_payload_valid !== want.payload_valid) begin
          $error("payload_valid expected %0b actual %0b", want.payload_valid,
                 out_payload_valid);
          fail_cnt++;
        end
        if (out_body_done !== want.body_done) begin
          $error("body_done expected %0b actual %0b", want.body_done, out_body_done);
          fail_cnt++;
        end
        if (out_format_error !== want.format_error) begin
          $error("format_error expected %0b actual %0b", want.format_error,
                 out_format_error);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic queue_body();
    int i;
    body_req_t req;
    for (i = 0; i < body_q.size(); i++) begin
      req.body_byte = body_q[i];
      req.body_start = (i == 0);
      put_req(req);
    end
    sent_cnt += body_q.size();
    body_q.delete();
  endtask

  task automatic add_chunk(input int unsigned n);
    int unsigned nd;
    int i;
    logic [3:0] v;
    nd = 1;
    while ((n >> (4 * nd)) != 0 && nd < 8) nd++;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(0, 8 - nd)) put_byte(CH_ZERO);
    end
    for (i = nd - 1; i >= 0; i--) begin
      v = 4'(n >> (4 * i));
      if (v < 10) put_byte(8'(CH_ZERO + v));
      else if ($urandom_range(0, 1)) put_byte(8'("A" + v - 10));
      else put_byte(8'("a" + v - 10));
    end
    if ($urandom_range(0, 4) == 0) add_text(";ext=1");
    add_text("\r\n");
    repeat (n) put_byte(8'($urandom_range(0, 255)));
    add_text("\r\n");
  endtask

  task automatic gen_body();
    int unsigned mode;
    int unsigned pos;
    repeat ($urandom_range(0, 4)) begin
      add_chunk(($urandom_range(0, 9) == 0) ? $urandom_range(13, 300) : $urandom_range(1, 12));
    end
    case ($urandom_range(0, 3))
      0: add_text("0");
      1: add_text("000");
      2: begin
      end
      default: add_text("0;end");
    endcase
    add_text("\r\n");
    if ($urandom_range(0, 1)) add_text("\r\n");
    mode = $urandom_range(0, 9);
    if (mode == 7 || mode == 8) begin
      pos = $urandom_range(0, body_q.size() - 1);
      if (mode == 7) body_q[pos] = 8'($urandom_range(0, 255));
      else body_q = body_q[0:pos];
      if ($urandom_range(0, 1)) add_text("x0\r\n\r\n");
    end else if (mode == 9) begin
      body_q.delete();
      repeat ($urandom_range(1, 20)) put_byte(8'($urandom_range(0, 255)));
    end
    queue_body();
  endtask

  task automatic wait_drained();
    while (body_bytes_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int target;
    send_idle_pct = 25;
    recv_stall_pct = 53;

    // An empty size line ends the body at once.
    add_text(";\r\n");
    queue_body();
    add_text("2\r\n");
    put_byte(8'h00);
    put_byte(8'hff);
    add_text("\r\n0\r\n");
    queue_body();
    // Nine digits overflow; the recovery scan restarts on a repeated zero.
    add_text("0000000000\r\n\r\n");
    queue_body();
    add_text("1\rX");
    queue_body();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 53 : 0;
      recv_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 25 : 0;
      target = sent_cnt + PHASE_BYTES;
      while (sent_cnt < target) gen_body();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
